>>> src/hdlc_bit_stuffing_framer_top_defines.svh
// ----------------------------------------------------------------------------
// HDLC framer assertion macros
// Shared assertion forms for the framer; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef HDLC_BIT_STUFFING_FRAMER_TOP_DEFINES_SVH
`define HDLC_BIT_STUFFING_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/hbsf_pkg.sv
// ----------------------------------------------------------------------------
// HDLC framer package
// Shared constants, byte command type and CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package hbsf_pkg;

   localparam logic [7:0]  FLAG_VALUE = 8'h7E;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [4:0]  ONES_RUN   = 5'h1F;
   localparam logic [7:0]  TRAIN_RESET = 8'h55;
   localparam int unsigned TRAIN_COUNT = 3;
   localparam int unsigned CMD_DEPTH   = 4;
   localparam int unsigned CMD_PTR_W   = $clog2(CMD_DEPTH);

   typedef enum logic [1:0] {
      STUFF_NONE  = 2'd0,
      STUFF_ALL   = 2'd1,
      STUFF_FIRST = 2'd2
   } stuff_mode_type;

   // One framed byte for the back end
   typedef struct packed {
      logic [7:0]     value;
      stuff_mode_type mode;
      logic           start;
      logic           eop;
      logic           done;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] crc;
      crc = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

>>> src/hbsf_front.sv
// ----------------------------------------------------------------------------
// HDLC framer front end
// Takes payload bytes, runs CRC; one byte command per cycle unless cmd_full.
// ----------------------------------------------------------------------------
module hbsf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      req_payload_byte,
   input  logic            req_last_byte,
   input  logic [7:0]      training_byte,
   output logic            cmd_push,
   output hbsf_pkg::cmd_type cmd_data,
   input  logic            cmd_full
);
   import hbsf_pkg::*;

   typedef enum logic [6:0] {
      PH_TRAIN  = 7'b0000001,
      PH_FLAG   = 7'b0000010,
      PH_DATA   = 7'b0000100,
      PH_CRC_LO = 7'b0001000,
      PH_CRC_HI = 7'b0010000,
      PH_CLOSE  = 7'b0100000,
      PH_ZERO   = 7'b1000000
   } phase_type;

   localparam int unsigned TCNT_W = $clog2(TRAIN_COUNT);

   phase_type         phase_ff, phase_in;
   logic              pend_ff, pend_in;
   logic              in_packet_ff, in_packet_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        data_ff;
   logic              last_ff;
   logic [TCNT_W-1:0] tcnt_ff, tcnt_in;
   logic              final_step;
   logic              accept;
   cmd_type           cmd;

   // Build the command for the current phase
   always_comb begin
      cmd        = '0;
      final_step = 1'b0;
      unique case (phase_ff)
         PH_TRAIN: begin
            cmd.value = training_byte;
            cmd.mode  = (training_byte == FLAG_VALUE) ? STUFF_NONE : STUFF_ALL;
            cmd.start = (tcnt_ff == '0);
         end
         PH_FLAG: begin
            cmd.value = FLAG_VALUE;
            cmd.mode  = STUFF_NONE;
         end
         PH_DATA: begin
            cmd.value  = data_ff;
            cmd.mode   = STUFF_ALL;
            cmd.done   = !last_ff;
            final_step = !last_ff;
         end
         PH_CRC_LO: begin
            cmd.value = ~crc_ff[7:0];
            cmd.mode  = STUFF_ALL;
         end
         PH_CRC_HI: begin
            cmd.value = ~crc_ff[15:8];
            cmd.mode  = STUFF_ALL;
         end
         PH_CLOSE: begin
            cmd.value = FLAG_VALUE;
            cmd.mode  = STUFF_FIRST;
         end
         PH_ZERO: begin
            cmd.value  = 8'h00;
            cmd.mode   = STUFF_ALL;
            cmd.eop    = 1'b1;
            cmd.done   = 1'b1;
            final_step = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign cmd_push = pend_ff && !cmd_full;
   assign cmd_data = cmd;
   assign req_full = pend_ff && !(cmd_push && final_step);
   assign accept   = req_push && !req_full;

   always_comb begin
      phase_in     = phase_ff;
      tcnt_in      = tcnt_ff;
      pend_in      = pend_ff;
      in_packet_in = in_packet_ff;
      crc_in       = crc_ff;
      if (cmd_push) begin
         unique case (phase_ff)
            PH_TRAIN: begin
               if (tcnt_ff == TCNT_W'(TRAIN_COUNT - 1)) begin
                  phase_in = PH_FLAG;
               end else begin
                  tcnt_in = tcnt_ff + 1'b1;
               end
            end
            PH_FLAG:   phase_in = PH_DATA;
            PH_DATA:   phase_in = PH_CRC_LO;
            PH_CRC_LO: phase_in = PH_CRC_HI;
            PH_CRC_HI: phase_in = PH_CLOSE;
            PH_CLOSE:  phase_in = PH_ZERO;
            PH_ZERO:   phase_in = PH_ZERO;
            default:   phase_in = PH_DATA;
         endcase
         if (final_step) begin
            pend_in = 1'b0;
         end
      end
      if (accept) begin
         pend_in      = 1'b1;
         tcnt_in      = '0;
         phase_in     = in_packet_ff ? PH_DATA : PH_TRAIN;
         in_packet_in = !req_last_byte;
         crc_in       = crc_byte(in_packet_ff ? crc_ff : CRC_INIT, req_payload_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         tcnt_ff      <= '0;
         pend_ff      <= 1'b0;
         in_packet_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tcnt_ff      <= tcnt_in;
         pend_ff      <= pend_in;
         in_packet_ff <= in_packet_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (accept) begin
         data_ff <= req_payload_byte;
         last_ff <= req_last_byte;
      end
   end

endmodule

>>> src/hbsf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// HDLC framer command queue
// Short queue of byte commands between the front and back ends.
// ----------------------------------------------------------------------------
module hbsf_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hbsf_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output hbsf_pkg::cmd_type pop_data,
   output logic              empty
);
   import hbsf_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (CMD_PTR_W + 1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{CMD_PTR_W{1'b0}}, do_push}
                           - {{CMD_PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/hbsf_back.sv
// ----------------------------------------------------------------------------
// HDLC framer back end
// Stuffs, NRZI-codes one byte command per cycle into a free result register.
// ----------------------------------------------------------------------------
module hbsf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  hbsf_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [9:0]        rsp_line_bits,
   output logic [3:0]        rsp_bit_count,
   output logic              rsp_end_of_packet,
   output logic              rsp_item_done
);
   import hbsf_pkg::*;

   typedef struct packed {
      logic [9:0] bits;
      logic [3:0] count;
      logic [4:0] recent;
      logic       level;
   } coded_type;

   function automatic coded_type code_byte(input logic [7:0]     value,
                                           input stuff_mode_type mode,
                                           input logic [4:0]     recent_i,
                                           input logic           level_i);
      coded_type r;
      logic      may;
      r.bits   = '0;
      r.count  = '0;
      r.recent = recent_i;
      r.level  = level_i;
      for (int j = 0; j < 8; j++) begin
         may = (mode == STUFF_ALL) || ((mode == STUFF_FIRST) && (j == 0));
         if (may && (r.recent == ONES_RUN)) begin
            r.level         = ~r.level;
            r.bits[r.count] = r.level;
            r.count         = r.count + 1'b1;
            r.recent        = {r.recent[3:0], 1'b0};
         end
         if (!value[j]) begin
            r.level = ~r.level;
         end
         r.bits[r.count] = r.level;
         r.count         = r.count + 1'b1;
         r.recent        = {r.recent[3:0], value[j]};
      end
      return r;
   endfunction

   logic       out_valid_ff, out_valid_in;
   logic [4:0] recent_ff, recent_in;
   logic       level_ff, level_in;
   logic [4:0] recent_start;
   logic       level_start;
   coded_type  coded;

   // Restart line state on the first byte of a packet
   assign recent_start = cmd_data.start ? 5'd0 : recent_ff;
   assign level_start  = cmd_data.start ? 1'b1 : level_ff;
   assign coded        = code_byte(cmd_data.value, cmd_data.mode, recent_start, level_start);

   assign cmd_pop   = !cmd_empty && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      recent_in    = recent_ff;
      level_in     = level_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (cmd_pop) begin
         out_valid_in = 1'b1;
         recent_in    = coded.recent;
         level_in     = coded.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         recent_ff    <= '0;
         level_ff     <= 1'b1;
      end else begin
         out_valid_ff <= out_valid_in;
         recent_ff    <= recent_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_line_bits     <= coded.bits;
         rsp_bit_count     <= coded.count;
         rsp_end_of_packet <= cmd_data.eop;
         rsp_item_done     <= cmd_data.done;
      end
   end

endmodule

>>> src/hdlc_bit_stuffing_framer_top.sv
// ----------------------------------------------------------------------------
// HDLC bit-stuffing framer, top level
// Frames payload bytes into NRZI-coded, bit-stuffed AIS/HDLC line bytes.
// ----------------------------------------------------------------------------
// Push payload bytes with req_last_byte marking the final byte of a packet;
// pop one framed byte per result, its line bits LSB first in rsp_line_bits
// with rsp_bit_count (8 to 10) valid bits. The first byte of a packet yields
// three training bytes, the opening flag and the byte itself (5 results); a
// middle byte yields 1 result; the last byte adds the two CRC bytes, the
// closing flag and a trailing zero byte marked by rsp_end_of_packet. A
// one-byte packet gives 9 results. rsp_item_done flags the last result of
// each pushed byte. Throughput is one framed byte per clock when input
// and output do not stall: the front sequencer issues one byte command
// per cycle into a four-entry command queue while it has room, and the
// back end stuffs and codes one command per cycle while its result register
// is empty or popped. A pushed byte is registered in the front end, the
// command queue and the result register in turn. Write csr_training_byte
// only while the block is idle; it takes effect at the next packet start.
// ----------------------------------------------------------------------------
`include "hdlc_bit_stuffing_framer_top_defines.svh"

module hdlc_bit_stuffing_framer_top (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_payload_byte,
   input  logic       req_last_byte,
   // result channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [9:0] rsp_line_bits,
   output logic [3:0] rsp_bit_count,
   output logic       rsp_end_of_packet,
   output logic       rsp_item_done,
   // configuration
   input  logic       csr_wr_en,
   input  logic [7:0] csr_training_byte
);
   import hbsf_pkg::*;

   logic [7:0] training_ff;
   logic       cmd_push;
   logic       cmd_full;
   logic       cmd_empty;
   logic       cmd_pop;
   cmd_type    cmd_wr_data;
   cmd_type    cmd_rd_data;

   // Training byte register; hold until rewritten
   always_ff @(posedge clock) begin
      if (reset) begin
         training_ff <= TRAIN_RESET;
      end else if (csr_wr_en) begin
         training_ff <= csr_training_byte;
      end
   end

   // Front: accept payload bytes, update CRC, expand into byte commands
   hbsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .training_byte    (training_ff),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wr_data),
      .cmd_full         (cmd_full)
   );

   // Queue: decouple command issue from coding so either side may stall
   hbsf_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   // Back: stuff, NRZI-code and register each framed byte
   hbsf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (cmd_empty),
      .cmd_data          (cmd_rd_data),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_line_bits     (rsp_line_bits),
      .rsp_bit_count     (rsp_bit_count),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_item_done     (rsp_item_done)
   );

   // A framed byte carries 8 data bits plus at most two stuffed zeros
   `HBSF_ASSERT_NOW(a_bit_count_range, clock, reset, !rsp_empty, (rsp_bit_count >= 4'd8) && (rsp_bit_count <= 4'd10), "bit count out of range")
   // Bits beyond the valid count stay zero
   `HBSF_ASSERT_NOW(a_unused_bits_zero, clock, reset, !rsp_empty && (rsp_bit_count != 4'd10), (rsp_line_bits[9] == 1'b0) && ((rsp_bit_count == 4'd9) || (rsp_line_bits[8] == 1'b0)), "line bits set beyond count")
   // The trailing zero byte always closes the transaction
   `HBSF_ASSERT_NOW(a_eop_done, clock, reset, !rsp_empty && rsp_end_of_packet, rsp_item_done, "end of packet without item done")
   // A command popped from the queue lands in the result register
   `HBSF_ASSERT_NEXT(a_pop_fills_result, clock, reset, cmd_pop, !rsp_empty, "popped command lost")

endmodule
